// ----- sv/pgcm_pkg.sv -----
// Types and constants shared by the gradient color map core and its cells.
// No dependencies.
`default_nettype none
package pgcm_pkg;

    localparam int unsigned Q_W = 17;
    localparam logic [Q_W-1:0] ONE_Q16 = 17'h10000;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]     command;
        logic [Q_W-1:0] low_bound;
        logic [Q_W-1:0] high_bound;
        logic [7:0]     start_red;
        logic [7:0]     start_green;
        logic [7:0]     start_blue;
        logic [7:0]     stop_red;
        logic [7:0]     stop_green;
        logic [7:0]     stop_blue;
        logic [Q_W-1:0] ratio;
    } in_word_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       matched;
        logic       accepted;
    } out_word_t;

    // one segment as held in a cell
    typedef struct packed {
        logic [Q_W-1:0] lo;
        logic [Q_W-1:0] hi;
        logic [7:0]     s_r;
        logic [7:0]     s_g;
        logic [7:0]     s_b;
        logic [7:0]     p_r;
        logic [7:0]     p_g;
        logic [7:0]     p_b;
    } seg_t;

endpackage
`default_nettype wire

// ----- sv/pgcm_cell.sv -----
// One table slot: holds a segment and forwards the scan token to its neighbor.
// Depends on pgcm_pkg.
`default_nettype none
module pgcm_cell
    import pgcm_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr,
    input  wire seg_t           wr_seg,
    input  wire logic           valid_in,
    input  wire logic           tok_in,
    input  wire logic [Q_W-1:0] ratio,
    output logic                tok_out,
    output logic                hit,
    output seg_t                seg
);

    seg_t seg_reg;
    logic tok_reg;

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            seg_reg <= wr_seg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_in;
        end
    end

    // the token is registered in each slot in turn; the slot compares when it holds it
    assign hit = tok_reg && valid_in && (ratio >= seg_reg.lo) && (ratio <= seg_reg.hi);
    assign tok_out = tok_reg && !hit;
    assign seg = seg_reg;

endmodule
`default_nettype wire

// ----- sv/pgcm_div.sv -----
// Restoring divider: quo = floor(num * 65536 / den), one quotient bit a cycle.
// Depends on pgcm_pkg.
`default_nettype none
module pgcm_div
    import pgcm_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           go,
    input  wire logic [Q_W-1:0] num,
    input  wire logic [Q_W-1:0] den,
    output logic                done,
    output logic [Q_W-1:0]      quo
);

    localparam int unsigned QB = 2 * Q_W;

    logic [Q_W:0]    rem_reg;
    logic [QB-1:0]   sh_reg;
    logic [Q_W-1:0]  den_reg;
    logic [5:0]      cnt_reg;
    logic            busy_reg;
    logic [Q_W+1:0]  trial;
    logic [Q_W:0]    rem_sh;

    assign rem_sh = {rem_reg[Q_W-1:0], sh_reg[QB-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(QB - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg <= '0;
            // dividend is num * 2^16
            sh_reg  <= {1'b0, num, 16'h0000};
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            sh_reg <= {sh_reg[QB-2:0], !trial[Q_W+1]};
            rem_reg <= trial[Q_W+1] ? rem_sh : trial[Q_W:0];
        end
    end

    // quotient bits shift into the low end; result is below 2^17 since num <= den
    assign quo = sh_reg[Q_W-1:0];

endmodule
`default_nettype wire

// ----- sv/pgcm_blend.sv -----
// Sequential blend of three channels through one shared multiply-add.
// Depends on pgcm_pkg.
`default_nettype none
module pgcm_blend
    import pgcm_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           go,
    input  wire logic [Q_W-1:0] perc,
    input  wire seg_t           seg,
    output logic                done,
    output logic [23:0]         rgb
);

    logic [1:0]     ch_reg;
    logic           busy_reg;
    logic [Q_W-1:0] perc_reg;
    logic [Q_W-1:0] inv_reg;
    logic [7:0]     a;
    logic [7:0]     b;
    logic [25:0]    sum;

    always_comb
    begin
        case (ch_reg)
            2'd0:    begin a = seg.s_r; b = seg.p_r; end
            2'd1:    begin a = seg.s_g; b = seg.p_g; end
            default: begin a = seg.s_b; b = seg.p_b; end
        endcase
    end

    assign sum = 26'(a) * 26'(perc_reg) + 26'(b) * 26'(inv_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            ch_reg   <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                ch_reg   <= '0;
            end
            else if (busy_reg)
            begin
                ch_reg <= ch_reg + 2'd1;
                if (ch_reg == 2'd2)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            perc_reg <= perc;
            inv_reg  <= ONE_Q16 - perc;
        end
        else if (busy_reg)
        begin
            rgb <= {rgb[15:0], sum[23:16]};
        end
    end

endmodule
`default_nettype wire

// ----- sv/piecewise_gradient_color_map_core.sv -----
// Gradient color map top level: a row of segment cells, a scan token,
// a serial divider and a shared blend unit. Depends on pgcm_pkg and submodules.
//
//  channel  | ports                         | handshake
//  command  | start, busy, cmd_in           | taken when start && !busy
//  result   | done, result                  | one cycle pulse, no back-pressure
//
// Append, clear and unused codes go from S_IDLE straight to S_OUT; done is registered from S_OUT.
// Lookup: token visits one slot per cycle in S_SCAN; a miss goes to S_OUT. A hit goes through
// S_WAIT, which launches the divider, then S_DIV, S_BLEND and S_OUT, and done is registered
// from S_OUT.
// busy stays high until done rises. Reset empties the table; stored segments are not cleared.
`default_nettype none
module piecewise_gradient_color_map_core
    import pgcm_pkg::*;
#(
    parameter int unsigned SEGMENT_SLOTS = 16
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire in_word_t  cmd_in,
    output logic           busy,
    output logic           done,
    output out_word_t      result
);

    localparam int unsigned CW = $clog2(SEGMENT_SLOTS + 1);
    localparam int unsigned IW = (SEGMENT_SLOTS > 1) ? $clog2(SEGMENT_SLOTS) : 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_DIV   = 6'b000100,
        S_BLEND = 6'b001000,
        S_OUT   = 6'b010000,
        S_WAIT  = 6'b100000
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  tick_reg;
    in_word_t       req_reg;
    out_word_t      res_reg;
    seg_t           hit_seg_reg;
    seg_t           new_seg;
    logic [Q_W-1:0] lo_f, hi_f;

    logic [SEGMENT_SLOTS:0]   tok;
    logic [SEGMENT_SLOTS-1:0] hits;
    seg_t                     segs [SEGMENT_SLOTS];
    seg_t                     hsel;
    logic                     any_hit;

    logic           div_go, div_done;
    logic [Q_W-1:0] quo;
    logic           bl_go, bl_done;
    logic [23:0]    rgb;
    logic [Q_W-1:0] perc;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        lo_f = cmd_in.low_bound;
        hi_f = cmd_in.high_bound;
        if (hi_f <= lo_f)
        begin
            lo_f = '0;
            hi_f = ONE_Q16;
        end
        if (lo_f > ONE_Q16) lo_f = ONE_Q16;
        if (hi_f > ONE_Q16) hi_f = ONE_Q16;
        new_seg = '{lo: lo_f, hi: hi_f,
                    s_r: cmd_in.start_red, s_g: cmd_in.start_green,
                    s_b: cmd_in.start_blue, p_r: cmd_in.stop_red,
                    p_g: cmd_in.stop_green, p_b: cmd_in.stop_blue};
    end

    logic accept, do_append;
    assign accept    = start && !busy;
    assign do_append = accept && (cmd_in.command == CMD_APPEND)
                       && (count_reg < CW'(SEGMENT_SLOTS));

    assign tok[0] = accept && (cmd_in.command == CMD_LOOKUP);

    genvar g;
    generate
        for (g = 0; g < SEGMENT_SLOTS; g++)
        begin : g_cell
            pgcm_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .wr       (do_append && (count_reg[IW-1:0] == IW'(g))),
                .wr_seg   (new_seg),
                .valid_in (count_reg > CW'(g)),
                .tok_in   (tok[g]),
                .ratio    (req_reg.ratio),
                .tok_out  (tok[g+1]),
                .hit      (hits[g]),
                .seg      (segs[g])
            );
        end
    endgenerate

    // at most one cell holds the token, so an OR-select is enough
    always_comb
    begin
        hsel = '0;
        for (int i = 0; i < SEGMENT_SLOTS; i++)
        begin
            if (hits[i]) hsel = hsel | segs[i];
        end
    end
    assign any_hit = |hits;

    pgcm_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (div_go),
        .num  (req_reg.ratio - hit_seg_reg.lo),
        .den  (hit_seg_reg.hi - hit_seg_reg.lo),
        .done (div_done),
        .quo  (quo)
    );

    assign perc = (hit_seg_reg.hi == hit_seg_reg.lo) ? '0 :
                  ((quo > ONE_Q16) ? ONE_Q16 : quo);

    pgcm_blend u_blend (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (bl_go),
        .perc (perc),
        .seg  (hit_seg_reg),
        .done (bl_done),
        .rgb  (rgb)
    );

    always_comb
    begin
        state_next = state_reg;
        div_go = 1'b0;
        bl_go  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = (cmd_in.command == CMD_LOOKUP) ? S_SCAN : S_OUT;
            end
            S_SCAN:
            begin
                if (any_hit)
                begin
                    state_next = S_WAIT;
                end
                else if (tick_reg == CW'(SEGMENT_SLOTS - 1) || tok[SEGMENT_SLOTS:1] == '0)
                begin
                    state_next = S_OUT;
                end
            end
            S_WAIT:
            begin
                div_go = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    bl_go = 1'b1;
                    state_next = S_BLEND;
                end
            end
            S_BLEND:
            begin
                if (bl_done) state_next = S_OUT;
            end
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            tick_reg  <= '0;
            done      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done      <= (state_reg == S_OUT);
            if (do_append)
                count_reg <= count_reg + CW'(1);
            else if (accept && cmd_in.command == CMD_CLEAR)
                count_reg <= '0;
            if (accept)
                tick_reg <= '0;
            else if (state_reg == S_SCAN)
                tick_reg <= tick_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= cmd_in;
            res_reg <= '{red: 8'd0, green: 8'd0, blue: 8'd0, matched: 1'b0,
                         accepted: do_append || (cmd_in.command == CMD_CLEAR)};
        end
        else
        begin
            if (state_reg == S_SCAN && any_hit)
                hit_seg_reg <= hsel;
            if (bl_done)
            begin
                res_reg.red     <= rgb[23:16];
                res_reg.green   <= rgb[15:8];
                res_reg.blue    <= rgb[7:0];
                res_reg.matched <= 1'b1;
            end
        end
        if (state_reg == S_OUT)
            result <= res_reg;
    end

`ifndef SYNTHESIS
    a_tok_one: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok[SEGMENT_SLOTS:1]))
        else $error("more than one scan token");
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(SEGMENT_SLOTS))
        else $error("segment count overflow");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == S_IDLE)
        else $error("result while busy");
    a_match_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.matched |-> !result.accepted)
        else $error("matched and accepted together");
`endif

endmodule
`default_nettype wire

// ----- tb/piecewise_gradient_color_map_core_test.sv -----
// Testbench for the gradient color map core: directed table, then random words
// checked against a behavioral predictor. Depends on pgcm_pkg and the core.
`timescale 1ns / 1ps
module piecewise_gradient_color_map_core_test;
    import pgcm_pkg::*;

    localparam int SLOTS = 16;
    localparam int WATCHDOG_CYCLES = 20000;

    typedef struct {
        cmd_t       cmd;
        logic [16:0] lo;
        logic [16:0] hi;
        logic [47:0] colors;
        logic [16:0] ratio;
        bit         has_expect;
        out_word_t  expect_word;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic start;
    in_word_t cmd_in;
    logic busy;
    logic done;
    out_word_t result;

    piecewise_gradient_color_map_core #(.SEGMENT_SLOTS(SLOTS)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd_in(cmd_in),
        .busy(busy), .done(done), .result(result)
    );

    // predictor state
    logic [16:0] seg_lo [SLOTS];
    logic [16:0] seg_hi [SLOTS];
    in_word_t    seg_word [SLOTS];
    int          seg_count;

    out_word_t   pending_colors[$];
    int          errors;
    int          idle_cycles;
    int          send_gap_pct;

    function automatic logic [7:0] mix_channel(logic [7:0] a, logic [7:0] b, logic [16:0] perc);
        logic [40:0] sum;
        sum = 41'(a) * 41'(perc) + 41'(b) * (41'(ONE_Q16) - 41'(perc));
        return sum[23:16];
    endfunction

    function automatic out_word_t predict_color(in_word_t w);
        out_word_t r;
        logic [16:0] lo;
        logic [16:0] hi;
        logic [40:0] q;
        logic [16:0] perc;
        r = '0;
        case (cmd_t'(w.command))
            CMD_APPEND: begin
                if (seg_count < SLOTS) begin
                    lo = w.low_bound;
                    hi = w.high_bound;
                    if (hi <= lo) begin
                        lo = '0;
                        hi = ONE_Q16;
                    end
                    if (lo > ONE_Q16) lo = ONE_Q16;
                    if (hi > ONE_Q16) hi = ONE_Q16;
                    seg_lo[seg_count] = lo;
                    seg_hi[seg_count] = hi;
                    seg_word[seg_count] = w;
                    seg_count++;
                    r.accepted = 1'b1;
                end
            end
            CMD_LOOKUP: begin
                for (int i = 0; i < seg_count; i++) begin
                    if (!r.matched && w.ratio >= seg_lo[i] && w.ratio <= seg_hi[i]) begin
                        perc = '0;
                        if (seg_hi[i] > seg_lo[i]) begin
                            q = (41'(w.ratio - seg_lo[i]) << 16) / 41'(seg_hi[i] - seg_lo[i]);
                            perc = (q > 41'(ONE_Q16)) ? ONE_Q16 : q[16:0];
                        end
                        r.red   = mix_channel(seg_word[i].start_red, seg_word[i].stop_red, perc);
                        r.green = mix_channel(seg_word[i].start_green, seg_word[i].stop_green, perc);
                        r.blue  = mix_channel(seg_word[i].start_blue, seg_word[i].stop_blue, perc);
                        r.matched = 1'b1;
                    end
                end
            end
            CMD_CLEAR: begin
                seg_count = 0;
                r.accepted = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // result checker and watchdog
    always @(posedge clk)
    begin
        if (done) begin
            if (pending_colors.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, result);
                errors++;
            end else begin
                out_word_t e;
                e = pending_colors.pop_front();
                if (result.red !== e.red || result.green !== e.green ||
                    result.blue !== e.blue || result.matched !== e.matched ||
                    result.accepted !== e.accepted) begin
                    $display("%0t: mismatch, expected %p, actual %p", $time, e, result);
                    errors++;
                end
            end
        end
        if (done || (start && !busy)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic in_word_t make_word(cmd_t c, logic [16:0] lo, logic [16:0] hi,
                                           logic [47:0] colors, logic [16:0] ratio);
        in_word_t w;
        w.command = c;
        w.low_bound = lo;
        w.high_bound = hi;
        {w.start_red, w.start_green, w.start_blue,
         w.stop_red, w.stop_green, w.stop_blue} = colors;
        w.ratio = ratio;
        return w;
    endfunction

    // drive one word on the falling edge and hold it until taken; busy is high
    // right after the accepting edge, so start may stay up until the next word
    task automatic send_word(in_word_t w, bit has_expect, out_word_t typed);
        out_word_t p;
        while ($urandom_range(99) < send_gap_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        cmd_in <= w;
        @(posedge clk);
        while (busy) @(posedge clk);
        p = predict_color(w);
        if (has_expect && p !== typed) begin
            $display("%0t: predictor disagrees with table, expected %p, actual %p",
                     $time, typed, p);
            errors++;
        end
        pending_colors.push_back(p);
        @(negedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_colors.size() != 0) @(negedge clk);
    endtask

    function automatic logic [16:0] random_q16();
        case ($urandom_range(7))
            0: return '0;
            1: return ONE_Q16;
            2: return 17'($urandom_range(131071));
            default: return 17'($urandom_range(65536));
        endcase
    endfunction

    function automatic logic [47:0] random_colors();
        return {$urandom, 16'($urandom)};
    endfunction

    task automatic random_phase(int count);
        in_word_t w;
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 30)
                w = make_word(CMD_APPEND, random_q16(), random_q16(), random_colors(), random_q16());
            else if (pick < 85)
                w = make_word(CMD_LOOKUP, random_q16(), random_q16(), random_colors(),
                              seg_count > 0 && $urandom_range(1) ?
                              17'(seg_lo[$urandom_range(seg_count - 1)] + $urandom_range(3))
                              : random_q16());
            else if (pick < 95)
                w = make_word(CMD_CLEAR, random_q16(), random_q16(), random_colors(), random_q16());
            else
                w = make_word(CMD_NONE, random_q16(), random_q16(), random_colors(), random_q16());
            w.command = w.command; // fields beyond command are random noise for clear/none
            send_word(w, 1'b0, '0);
        end
    endtask

    stim_row_t directed[$];

    function automatic stim_row_t row(cmd_t c, logic [16:0] lo, logic [16:0] hi,
                                      logic [47:0] colors, logic [16:0] ratio,
                                      bit has_e, out_word_t e);
        stim_row_t s;
        s.cmd = c; s.lo = lo; s.hi = hi; s.colors = colors; s.ratio = ratio;
        s.has_expect = has_e; s.expect_word = e;
        return s;
    endfunction

    initial
    begin
        out_word_t none;
        none = '0;
        errors = 0;
        idle_cycles = 0;
        seg_count = 0;
        send_gap_pct = 11;
        start = 1'b0;
        cmd_in = '0;
        rst_n = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // lookup on empty table, unused code, clear
        directed.push_back(row(CMD_LOOKUP, '0, '0, '0, 17'h08000, 1, none));
        directed.push_back(row(CMD_NONE, 17'h1ffff, 17'h1ffff, '1, 17'h1ffff, 1, none));
        directed.push_back(row(CMD_CLEAR, '0, '0, '0, '0, 1, '{8'd0, 8'd0, 8'd0, 1'b0, 1'b1}));
        // inverted bounds become full range
        directed.push_back(row(CMD_APPEND, 17'h10000, 17'h00000, 48'hff00ff_00ff00, '0,
                               1, '{8'd0, 8'd0, 8'd0, 1'b0, 1'b1}));
        // ratio 0 gives stop, ratio 1.0 gives start
        directed.push_back(row(CMD_LOOKUP, '0, '0, '0, 17'h00000,
                               1, '{8'h00, 8'hff, 8'h00, 1'b1, 1'b0}));
        directed.push_back(row(CMD_LOOKUP, '0, '0, '0, 17'h10000,
                               1, '{8'hff, 8'h00, 8'hff, 1'b1, 1'b0}));
        // ratio above one never matches
        directed.push_back(row(CMD_LOOKUP, '0, '0, '0, 17'h1ffff, 1, none));
        directed.push_back(row(CMD_LOOKUP, '0, '0, '0, 17'h08000, 0, none));
        directed.push_back(row(CMD_CLEAR, '0, '0, '0, '0, 1, '{8'd0, 8'd0, 8'd0, 1'b0, 1'b1}));
        // both bounds clamp to one: zero width, gives stop color
        directed.push_back(row(CMD_APPEND, 17'h1fff0, 17'h1ffff, 48'h123456_abcdef, '0,
                               1, '{8'd0, 8'd0, 8'd0, 1'b0, 1'b1}));
        directed.push_back(row(CMD_LOOKUP, '0, '0, '0, 17'h10000,
                               1, '{8'hab, 8'hcd, 8'hef, 1'b1, 1'b0}));
        directed.push_back(row(CMD_APPEND, 17'h04000, 17'h0c000, 48'hffffff_000000, '0, 0, none));
        directed.push_back(row(CMD_LOOKUP, '0, '0, '0, 17'h06000, 0, none));
        directed.push_back(row(CMD_LOOKUP, '0, '0, '0, 17'h03fff, 1, none));
        // fill the table, then one more append is rejected
        for (int k = 0; k < 14; k++)
            directed.push_back(row(CMD_APPEND, 17'(k * 4096), 17'(k * 4096 + 8191),
                                   48'h5a5a5a_a5a5a5, '0, 0, none));
        directed.push_back(row(CMD_APPEND, '0, 17'h10000, '0, '0, 1, none));
        directed.push_back(row(CMD_LOOKUP, '0, '0, '0, 17'h0a123, 0, none));
        directed.push_back(row(CMD_CLEAR, '0, '0, '0, '0, 1, '{8'd0, 8'd0, 8'd0, 1'b0, 1'b1}));

        foreach (directed[i])
            send_word(make_word(directed[i].cmd, directed[i].lo, directed[i].hi,
                                directed[i].colors, directed[i].ratio),
                      directed[i].has_expect, directed[i].expect_word);

        random_phase(180);
        // hold off until the block has answered everything
        drain_results();
        send_gap_pct = 70;
        random_phase(170);
        send_gap_pct = 0;
        random_phase(180);

        drain_results();
        repeat (80) @(negedge clk);
        if (errors == 0 && pending_colors.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ----- files.f -----
sv/pgcm_pkg.sv
sv/pgcm_cell.sv
sv/pgcm_div.sv
sv/pgcm_blend.sv
sv/piecewise_gradient_color_map_core.sv
tb/piecewise_gradient_color_map_core_test.sv
